FILE: rtl/core/trr_pkg.sv
package trr_pkg;

    // Frame layout and protocol constants.
    localparam int unsigned HDR_BYTES       = 54;
    localparam int unsigned MAX_FRAME_BYTES = 2047;
    localparam int unsigned CNT_W           = 11;
    localparam int unsigned IDX_W           = 6;
    localparam int unsigned SUM_W           = 21;

    localparam logic [15:0] ETH_TYPE_IPV4   = 16'h0800;
    localparam logic [7:0]  PROTO_TCP       = 8'h06;
    localparam logic [7:0]  FLAGS_FIN_ACK   = 8'h11;
    localparam logic [7:0]  FLAGS_RST_ACK   = 8'h14;
    localparam logic [7:0]  TCP_OFFSET_BYTE = 8'h50;
    localparam logic [15:0] IP_TOTAL_LEN    = 16'd40;
    // Protocol number plus TCP length of the pseudo-header.
    localparam logic [15:0] TCP_PSEUDO_SUM  = 16'h001A;
    localparam logic [15:0] FIN_PORT_RESET  = 16'd80;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             rx_open;
        logic             calc_ack;
        logic             calc_sum;
        logic             fold;
        logic             fetch;
        logic             load;
        logic [IDX_W-1:0] rd_idx;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic rx_last;
        logic frame_ok;
        logic out_taken;
    } t_sts;

    // Stored header byte that feeds reply byte k.
    function automatic logic [IDX_W-1:0] src_addr(input logic [IDX_W-1:0] k);
        logic [IDX_W-1:0] a;
        a = k;
        if (k <= 6'd5) begin
            a = k + 6'd6;
        end else if (k <= 6'd11) begin
            a = k - 6'd6;
        end else if (k >= 6'd26 && k <= 6'd29) begin
            a = k + 6'd4;
        end else if (k >= 6'd30 && k <= 6'd33) begin
            a = k - 6'd4;
        end else if (k >= 6'd34 && k <= 6'd35) begin
            a = k + 6'd2;
        end else if (k >= 6'd36 && k <= 6'd37) begin
            a = k - 6'd2;
        end else if (k >= 6'd38 && k <= 6'd41) begin
            a = k + 6'd4;
        end
        return a;
    endfunction

endpackage

FILE: rtl/core/trr_ctrl.sv
module trr_ctrl
    import trr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_RX, S_ACK, S_SUM, S_FOLD1, S_FOLD2, S_FETCH, S_LOAD, S_HOLD
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_k, n_k;

    // Next state and reply byte index.
    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        unique case (r_state)
            S_RX: begin
                if (i_sts.rx_last) n_state = S_ACK;
            end
            S_ACK: begin
                n_state = i_sts.frame_ok ? S_SUM : S_RX;
            end
            S_SUM:   n_state = S_FOLD1;
            S_FOLD1: n_state = S_FOLD2;
            S_FOLD2: begin
                n_state = S_FETCH;
                n_k     = '0;
            end
            S_FETCH: n_state = S_LOAD;
            S_LOAD:  n_state = S_HOLD;
            S_HOLD: begin
                if (i_sts.out_taken) begin
                    if (r_k == IDX_W'(HDR_BYTES - 1)) begin
                        n_state = S_RX;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_FETCH;
                    end
                end
            end
            default: n_state = S_RX;
        endcase
    end

    // State and index registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RX;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    // Commands decoded from the state.
    always_comb begin
        o_cmd          = '0;
        o_cmd.rx_open  = (r_state == S_RX);
        o_cmd.calc_ack = (r_state == S_ACK);
        o_cmd.calc_sum = (r_state == S_SUM);
        o_cmd.fold     = (r_state == S_FOLD1) || (r_state == S_FOLD2);
        o_cmd.fetch    = (r_state == S_FETCH);
        o_cmd.load     = (r_state == S_LOAD);
        o_cmd.rd_idx   = r_k;
    end

endmodule

FILE: rtl/core/trr_dp.sv
module trr_dp
    import trr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic [7:0]       mem [HDR_BYTES];
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [CNT_W-1:0] r_total;
    logic [15:0]      r_fin_port;
    logic [7:0]       r_type_hi, r_type_lo, r_proto;
    logic [15:0]      r_sport, r_dport;
    logic [31:0]      r_seq, r_ack;
    logic [7:0]       r_flags;
    logic [SUM_W-1:0] r_ipsum, r_tcpsum;
    logic [7:0]       r_rdata;
    logic             r_ovalid, r_olast;
    logic [7:0]       r_obyte, n_obyte;
    logic             accept;
    logic [15:0]      word;
    logic             in_ip, in_tcp;
    logic [CNT_W-1:0] payload;
    logic [15:0]      ip_csum, tcp_csum;

    assign accept     = i_in_valid && i_cmd.rx_open;
    assign o_in_stall = !i_cmd.rx_open;
    assign n_cnt      = (r_cnt < CNT_W'(MAX_FRAME_BYTES)) ? r_cnt + 1'b1 : r_cnt;
    assign word       = r_cnt[0] ? {8'h00, i_frame_byte} : {i_frame_byte, 8'h00};

    // Header words that enter each checksum as they arrive.
    assign in_ip  = (r_cnt >= 11'd14) && (r_cnt <= 11'd33) &&
                    (r_cnt != 11'd16) && (r_cnt != 11'd17) &&
                    (r_cnt != 11'd24) && (r_cnt != 11'd25);
    assign in_tcp = ((r_cnt >= 11'd26) && (r_cnt <= 11'd37)) ||
                    ((r_cnt >= 11'd42) && (r_cnt <= 11'd45)) ||
                    (r_cnt == 11'd48) || (r_cnt == 11'd49) ||
                    (r_cnt == 11'd52) || (r_cnt == 11'd53);

    assign payload  = (r_total == CNT_W'(HDR_BYTES)) ? CNT_W'(1) : r_total - CNT_W'(HDR_BYTES);
    assign ip_csum  = ~r_ipsum[15:0];
    assign tcp_csum = ~r_tcpsum[15:0];

    // Header store: written while the first bytes arrive, read one byte at a time.
    always_ff @(posedge i_clk) begin
        if (accept && (r_cnt < CNT_W'(HDR_BYTES))) mem[r_cnt[IDX_W-1:0]] <= i_frame_byte;
        if (i_cmd.fetch) r_rdata <= mem[src_addr(i_cmd.rd_idx)];
    end

    // Byte count and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_fin_port <= FIN_PORT_RESET;
        end else begin
            if (accept) r_cnt <= i_last_byte ? '0 : n_cnt;
            if (i_cfg_we) r_fin_port <= i_cfg_wdata;
        end
    end

    // Field captures and running checksums during reception, then acknowledge, flags, sums and folds.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (i_last_byte) r_total <= n_cnt;
            if (r_cnt == 11'd12) r_type_hi <= i_frame_byte;
            if (r_cnt == 11'd13) r_type_lo <= i_frame_byte;
            if (r_cnt == 11'd23) r_proto <= i_frame_byte;
            if (r_cnt == 11'd34 || r_cnt == 11'd35) r_sport <= {r_sport[7:0], i_frame_byte};
            if (r_cnt == 11'd36 || r_cnt == 11'd37) r_dport <= {r_dport[7:0], i_frame_byte};
            if (r_cnt >= 11'd38 && r_cnt <= 11'd41) r_seq <= {r_seq[23:0], i_frame_byte};
            r_ipsum  <= ((r_cnt == '0) ? '0 : r_ipsum) +
                        (in_ip ? SUM_W'(word) : SUM_W'(0));
            r_tcpsum <= ((r_cnt == '0) ? '0 : r_tcpsum) +
                        (in_tcp ? SUM_W'(word) : SUM_W'(0));
        end else if (i_cmd.calc_ack) begin
            r_ack   <= r_seq + 32'(payload);
            r_flags <= (r_sport == r_fin_port || r_dport == r_fin_port) ?
                       FLAGS_FIN_ACK : FLAGS_RST_ACK;
        end else if (i_cmd.calc_sum) begin
            r_ipsum  <= r_ipsum + SUM_W'(IP_TOTAL_LEN);
            r_tcpsum <= r_tcpsum + SUM_W'(r_ack[31:16]) + SUM_W'(r_ack[15:0]) +
                        SUM_W'({TCP_OFFSET_BYTE, r_flags}) + SUM_W'(TCP_PSEUDO_SUM);
        end else if (i_cmd.fold) begin
            r_ipsum  <= SUM_W'(r_ipsum[15:0]) + SUM_W'(r_ipsum[SUM_W-1:16]);
            r_tcpsum <= SUM_W'(r_tcpsum[15:0]) + SUM_W'(r_tcpsum[SUM_W-1:16]);
        end
    end

    // Reply byte: stored byte or a rewritten field.
    always_comb begin
        unique case (i_cmd.rd_idx)
            6'd16:   n_obyte = IP_TOTAL_LEN[15:8];
            6'd17:   n_obyte = IP_TOTAL_LEN[7:0];
            6'd24:   n_obyte = ip_csum[15:8];
            6'd25:   n_obyte = ip_csum[7:0];
            6'd42:   n_obyte = r_ack[31:24];
            6'd43:   n_obyte = r_ack[23:16];
            6'd44:   n_obyte = r_ack[15:8];
            6'd45:   n_obyte = r_ack[7:0];
            6'd46:   n_obyte = TCP_OFFSET_BYTE;
            6'd47:   n_obyte = r_flags;
            6'd50:   n_obyte = tcp_csum[15:8];
            6'd51:   n_obyte = tcp_csum[7:0];
            default: n_obyte = r_rdata;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load) begin
            r_ovalid <= 1'b1;
        end else if (r_ovalid && !i_out_stall) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.load) begin
            r_obyte <= n_obyte;
            r_olast <= (i_cmd.rd_idx == IDX_W'(HDR_BYTES - 1));
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_byte  = r_obyte;
    assign o_out_last  = r_olast;

    assign o_sts.rx_last   = accept && i_last_byte;
    assign o_sts.frame_ok  = (r_total >= CNT_W'(HDR_BYTES)) &&
                             ({r_type_hi, r_type_lo} == ETH_TYPE_IPV4) &&
                             (r_proto == PROTO_TCP);
    assign o_sts.out_taken = r_ovalid && !i_out_stall;

endmodule

FILE: rtl/core/tcp_reset_responder_unit.sv
// Channel   Direction  Handshake                 Word
// input     in         i_in_valid / o_in_stall   i_frame_byte, i_last_byte
// output    out        o_out_valid / i_out_stall o_out_byte, o_out_last
// config    in         i_cfg_we                  i_cfg_wdata (fin_port)
//
// Frame bytes are taken one per cycle while the block is receiving.
// After the last byte the block computes the acknowledge and checksum sums
// and folds them, then sends each reply byte (header store read, load, hand-over).
// The reply for a valid frame is 54 words; input stalls until it has gone.
// Reset is synchronous; the header store is not cleared.
module tcp_reset_responder_unit
    import trr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_frame_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer.
    trr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // Header store, sums and output register.
    trr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_frame_byte (i_frame_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

`ifndef SYNTHESIS
    // A reply word is never offered while frame bytes are being taken.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall) else $error("reply offered while receiving");

    // The final reply word ends the reply.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_last) |=> !o_out_valid)
        else $error("reply continues after last word");

    // Within a frame the block keeps receiving.
    a_rx_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !i_last_byte) |=> !o_in_stall)
        else $error("input stalled inside a frame");
`endif

endmodule

FILE: tb/tcp_reset_responder_unit_tb.sv
module tcp_reset_responder_unit_tb;
    import trr_pkg::*;

    typedef enum logic [1:0] {
        PACE_FREE,
        PACE_SEND_IDLE,
        PACE_RECV_STALL,
        PACE_BOTH
    } t_pace;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_frame_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic        i_cfg_we;
    logic [15:0] i_cfg_wdata;

    // Predictor state: header copy, length count and the FIN port.
    logic [7:0]  hdr_copy [HDR_BYTES];
    int unsigned frame_len;
    logic [15:0] fin_port_copy;

    // Reply words still to come, oldest first.
    logic [8:0]  reply_words [$];

    t_pace       pace;
    int unsigned hold_cycles;
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned replies_seen;

    tcp_reset_responder_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_frame_byte (i_frame_byte),
        .i_last_byte  (i_last_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200_000_000;
        $display("[tcp_reset_responder_unit] ERROR");
        $finish;
    end

    // Unfolded sum of the 16-bit words of the reply bytes from index lo, n bytes long.
    function automatic logic [31:0] word_sum(input logic [7:0] r [HDR_BYTES],
                                             input int lo, input int n,
                                             input logic [31:0] acc);
        logic [31:0] s;
        s = acc;
        for (int i = lo; i < lo + n; i += 2) begin
            s += {r[i], r[i+1]};
        end
        return s;
    endfunction

    function automatic logic [15:0] fold_invert(input logic [31:0] acc);
        logic [31:0] s;
        s = acc;
        while (s[31:16] != 0) begin
            s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
        end
        return ~s[15:0];
    endfunction

    // Builds the teardown reply from the stored header and queues its words.
    task automatic predict_reply(input int unsigned total);
        logic [7:0]  r [HDR_BYTES];
        logic [15:0] sport, dport, csum;
        logic [31:0] payload, ack_num, acc;
        for (int k = 0; k < HDR_BYTES; k++) begin
            r[k] = hdr_copy[k];
        end
        for (int k = 0; k < 6; k++) begin
            r[k]   = hdr_copy[k+6];
            r[k+6] = hdr_copy[k];
        end
        r[16] = IP_TOTAL_LEN[15:8];
        r[17] = IP_TOTAL_LEN[7:0];
        for (int k = 0; k < 4; k++) begin
            r[26+k] = hdr_copy[30+k];
            r[30+k] = hdr_copy[26+k];
            r[38+k] = hdr_copy[42+k];
        end
        r[24] = 8'd0;
        r[25] = 8'd0;
        csum = fold_invert(word_sum(r, 14, 20, 32'd0));
        r[24] = csum[15:8];
        r[25] = csum[7:0];
        sport = {hdr_copy[34], hdr_copy[35]};
        dport = {hdr_copy[36], hdr_copy[37]};
        r[34] = dport[15:8];
        r[35] = dport[7:0];
        r[36] = sport[15:8];
        r[37] = sport[7:0];
        payload = total - HDR_BYTES;
        if (payload == 0) begin
            payload = 1;
        end
        ack_num = {hdr_copy[38], hdr_copy[39], hdr_copy[40], hdr_copy[41]} + payload;
        {r[42], r[43], r[44], r[45]} = ack_num;
        r[46] = TCP_OFFSET_BYTE;
        r[47] = (sport == fin_port_copy || dport == fin_port_copy) ?
                FLAGS_FIN_ACK : FLAGS_RST_ACK;
        r[50] = 8'd0;
        r[51] = 8'd0;
        acc = word_sum(r, 26, 8, 32'd0) + TCP_PSEUDO_SUM;
        acc = word_sum(r, 34, 20, acc);
        csum = fold_invert(acc);
        r[50] = csum[15:8];
        r[51] = csum[7:0];
        for (int k = 0; k < HDR_BYTES; k++) begin
            reply_words.push_back({(k == HDR_BYTES - 1), r[k]});
        end
    endtask

    // Updates the predictor with one accepted frame word.
    task automatic absorb_byte(input logic [7:0] b, input logic last);
        int unsigned total;
        if (frame_len < HDR_BYTES) begin
            hdr_copy[frame_len] = b;
        end
        if (frame_len < MAX_FRAME_BYTES) begin
            frame_len++;
        end
        if (last) begin
            total = frame_len;
            frame_len = 0;
            if (total >= HDR_BYTES && {hdr_copy[12], hdr_copy[13]} == ETH_TYPE_IPV4 &&
                hdr_copy[23] == PROTO_TCP) begin
                predict_reply(total);
            end
        end
    endtask

    function automatic int unsigned send_idle_pct();
        return (pace == PACE_SEND_IDLE) ? 70 : (pace == PACE_BOTH) ? 12 : 0;
    endfunction

    function automatic int unsigned recv_stall_pct();
        return (pace == PACE_RECV_STALL) ? 70 : (pace == PACE_BOTH) ? 12 : 0;
    endfunction

    // Offers one word and returns at the edge where it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_frame_byte <= b;
        i_last_byte  <= last;
        @(negedge i_clk);
        while (o_in_stall) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        absorb_byte(b, last);
    endtask

    task automatic send_frame(input logic [7:0] bytes [$]);
        for (int i = 0; i < bytes.size(); i++) begin
            send_byte(bytes[i], i == bytes.size() - 1);
        end
    endtask

    // Random frame of the given length with a chosen type, protocol and ports.
    function automatic void make_frame(output logic [7:0] f [$], input int len,
                                       input logic [15:0] etype, input logic [7:0] proto,
                                       input logic [15:0] sport, input logic [15:0] dport);
        f = {};
        for (int i = 0; i < len; i++) begin
            f.push_back(8'($urandom));
        end
        if (len > 13) begin
            f[12] = etype[15:8];
            f[13] = etype[7:0];
        end
        if (len > 23) begin
            f[23] = proto;
        end
        if (len > 37) begin
            {f[34], f[35], f[36], f[37]} = {sport, dport};
        end
    endfunction

    // Ends the current phase: all words in, all replies out, block settled.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (reply_words.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_fin_port(input logic [15:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        fin_port_copy = v;
    endtask

    // Receiver: random stalls by pace, plus long hold-offs on request.
    always @(posedge i_clk) begin
        if (hold_cycles != 0) begin
            i_out_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < recv_stall_pct());
        end
    end

    // Compares each reply word with the oldest expectation.
    always @(posedge i_clk) begin
        logic [8:0] want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (reply_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected reply word byte=%h last=%b", o_out_byte, o_out_last);
                end
            end else begin
                want = reply_words.pop_front();
                words_checked++;
                if (o_out_last) begin
                    replies_seen++;
                end
                if (o_out_byte !== want[7:0] || o_out_last !== want[8]) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("reply word mismatch: expected byte=%h last=%b, got byte=%h last=%b",
                                 want[7:0], want[8], o_out_byte, o_out_last);
                    end
                end
            end
        end
    end

    // Minimum length with FIN on the source port, a rejected protocol and a short frame.
    task automatic test_directed();
        logic [7:0] f [$];
        make_frame(f, 54, ETH_TYPE_IPV4, PROTO_TCP, 16'd80, 16'd4321);
        send_frame(f);
        make_frame(f, 54, ETH_TYPE_IPV4, 8'h11, 16'd1, 16'd2);
        send_frame(f);
        make_frame(f, 10, ETH_TYPE_IPV4, PROTO_TCP, 16'd1, 16'd2);
        send_frame(f);
    endtask

    // Largest FIN port with an all-ones header, which also has a long header length field.
    task automatic test_fin_port();
        logic [7:0] f [$];
        write_fin_port(16'hFFFF);
        make_frame(f, 54, ETH_TYPE_IPV4, PROTO_TCP, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 54; i++) begin
            if (i != 12 && i != 13 && i != 23) begin
                f[i] = 8'hFF;
            end
        end
        send_frame(f);
    endtask

    // Mostly well-formed TCP frames with random content, some noise.
    task automatic random_frame();
        logic [7:0]  f [$];
        logic [15:0] sport, dport;
        int          kind, len;
        kind  = $urandom_range(99);
        len   = $urandom_range(54, 64);
        sport = ($urandom_range(3) == 0) ? fin_port_copy : 16'($urandom);
        dport = ($urandom_range(3) == 0) ? fin_port_copy : 16'($urandom);
        if (kind < 75) begin
            make_frame(f, len, ETH_TYPE_IPV4, PROTO_TCP, sport, dport);
        end else if (kind < 85) begin
            make_frame(f, $urandom_range(1, 53), ETH_TYPE_IPV4, PROTO_TCP, sport, dport);
        end else begin
            make_frame(f, len, 16'($urandom), 8'($urandom), sport, dport);
        end
        send_frame(f);
    endtask

    task automatic test_random();
        t_pace modes [4] = '{PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH};
        foreach (modes[m]) begin
            pace = modes[m];
            random_frame();
            if (m == 2) begin
                write_fin_port(16'($urandom));
            end
        end
        pace = PACE_FREE;
    endtask

    // Long receiver hold-off while frames keep coming, then a full pause.
    task automatic test_backpressure();
        logic [7:0] f [$];
        hold_cycles = 600;
        make_frame(f, 54, ETH_TYPE_IPV4, PROTO_TCP, 16'd1000, 16'd2000);
        send_frame(f);
        make_frame(f, 10, ETH_TYPE_IPV4, PROTO_TCP, 16'd1, 16'd2);
        send_frame(f);
        drain();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_frame_byte  = 8'd0;
        i_last_byte   = 1'b0;
        i_out_stall   = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 16'd0;
        pace          = PACE_FREE;
        hold_cycles   = 0;
        mismatches    = 0;
        words_checked = 0;
        replies_seen  = 0;
        frame_len     = 0;
        fin_port_copy = FIN_PORT_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_fin_port();
        test_random();
        test_backpressure();
        drain();

        if (reply_words.size() != 0) begin
            mismatches++;
        end
        $display("Covered directed, FIN port, random and back-pressure frames: %0d replies, %0d words.",
                 replies_seen, words_checked);
        if (mismatches == 0) begin
            $display("[tcp_reset_responder_unit] OK");
        end else begin
            $display("[tcp_reset_responder_unit] ERROR");
        end
        $finish;
    end

endmodule
